// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL top level of the encoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/b64e_pkg.sv =====
// Types, constants and the symbol function of the Base64 stream encoder.
`default_nettype none

package b64e_pkg;

    localparam int unsigned CHARS_PER_GROUP = 4;
    localparam int unsigned QUEUE_DEPTH     = 2;

    localparam logic [7:0] PAD_CHAR    = 8'h3D;
    localparam logic [5:0] SEXTET_MASK = 6'h3F;

    localparam logic [1:0] CNT_EMPTY = 2'd0;
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_TWO   = 2'd2;

    localparam logic [1:0] LAST_CHAR_IDX = 2'(CHARS_PER_GROUP - 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } byte_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_in_run;
        logic       message_done;
    } char_item_t;

    typedef struct packed {
        logic [CHARS_PER_GROUP-1:0][7:0] chars;
        logic                            done;
    } group_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [7:0] sextet_char(input logic [5:0] sextet);
        logic [5:0] s;
        logic [7:0] ch;
        s = sextet & SEXTET_MASK;
        if (s < 6'd26)
        begin
            ch = 8'h41 + {2'b00, s};
        end
        else if (s < 6'd52)
        begin
            ch = 8'h61 + {2'b00, s - 6'd26};
        end
        else if (s < 6'd62)
        begin
            ch = 8'h30 + {2'b00, s - 6'd52};
        end
        else if (s == 6'd62)
        begin
            ch = 8'h2B;
        end
        else
        begin
            ch = 8'h2F;
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== src/b64e_front.sv =====
// Front end: accepts bytes, holds the pending group and builds character groups.
`default_nettype none

module b64e_front
    import b64e_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          byte_valid,
    output logic               byte_ready,
    input  wire byte_item_t    byte_item,
    input  wire queue_status_t q_status,
    output logic               push,
    output group_t             push_group
);

    logic [15:0] pending_bytes_reg, pending_bytes_next;
    logic [1:0]  pending_count_reg, pending_count_next;
    logic        accept;
    logic        complete;
    logic [23:0] group_bits;

    assign byte_ready = !q_status.full;
    assign accept     = byte_valid && byte_ready;
    assign complete   = byte_item.end_of_message || (pending_count_reg >= CNT_TWO);
    assign push       = accept && complete;

    always_comb
    begin
        group_bits       = '0;
        push_group.chars = '0;
        push_group.done  = byte_item.end_of_message;
        unique case (pending_count_reg)
            CNT_EMPTY:
            begin
                group_bits          = {byte_item.data_byte, 16'h0000};
                push_group.chars[0] = sextet_char(group_bits[23:18]);
                push_group.chars[1] = sextet_char(group_bits[17:12]);
                push_group.chars[2] = PAD_CHAR;
                push_group.chars[3] = PAD_CHAR;
            end
            CNT_ONE:
            begin
                group_bits          = {pending_bytes_reg[15:8], byte_item.data_byte, 8'h00};
                push_group.chars[0] = sextet_char(group_bits[23:18]);
                push_group.chars[1] = sextet_char(group_bits[17:12]);
                push_group.chars[2] = sextet_char(group_bits[11:6]);
                push_group.chars[3] = PAD_CHAR;
            end
            default:
            begin
                group_bits          = {pending_bytes_reg, byte_item.data_byte};
                push_group.chars[0] = sextet_char(group_bits[23:18]);
                push_group.chars[1] = sextet_char(group_bits[17:12]);
                push_group.chars[2] = sextet_char(group_bits[11:6]);
                push_group.chars[3] = sextet_char(group_bits[5:0]);
            end
        endcase
    end

    always_comb
    begin
        pending_bytes_next = pending_bytes_reg;
        pending_count_next = pending_count_reg;
        if (accept)
        begin
            if (complete)
            begin
                pending_bytes_next = '0;
                pending_count_next = CNT_EMPTY;
            end
            else if (pending_count_reg == CNT_EMPTY)
            begin
                pending_bytes_next = {byte_item.data_byte, 8'h00};
                pending_count_next = CNT_ONE;
            end
            else
            begin
                pending_bytes_next = {pending_bytes_reg[15:8], byte_item.data_byte};
                pending_count_next = CNT_TWO;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_bytes_reg <= '0;
            pending_count_reg <= CNT_EMPTY;
        end
        else
        begin
            pending_bytes_reg <= pending_bytes_next;
            pending_count_reg <= pending_count_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/b64e_queue.sv =====
// Two-entry queue of character groups between front and back end.
`default_nettype none

module b64e_queue
    import b64e_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire group_t push_group,
    input  wire logic   pop,
    output group_t      head,
    output queue_status_t q_status
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    group_t             entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign q_status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head           = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_group;
        end
    end

endmodule

`default_nettype wire

// ===== src/b64e_back.sv =====
// Back end: sends the four characters of the head group one per cycle while char_ready is high.
`default_nettype none

module b64e_back
    import b64e_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire group_t        head,
    input  wire queue_status_t q_status,
    output logic               pop,
    output logic               char_valid,
    input  wire logic          char_ready,
    output char_item_t         char_item
);

    logic [1:0] idx_reg, idx_next;
    logic       accept;
    logic       last;

    assign char_valid             = !q_status.empty;
    assign accept                 = char_valid && char_ready;
    assign last                   = (idx_reg == LAST_CHAR_IDX);
    assign pop                    = accept && last;
    assign char_item.out_char     = head.chars[idx_reg];
    assign char_item.last_in_run  = last;
    assign char_item.message_done = last && head.done;

    always_comb
    begin
        idx_next = idx_reg;
        if (accept)
        begin
            idx_next = last ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/base64_stream_encoder.sv =====
// Top level of the Base64 stream encoder: front end, group queue, back end.
//
//  channel | direction | payload      | handshake
//  byte    | in        | byte_item_t  | byte_valid / byte_ready
//  char    | out       | char_item_t  | char_valid / char_ready
//
// A byte is taken every cycle while the two-entry group queue has room.
// A byte that completes a group (third byte or end of message) pushes four
// characters, which leave one per cycle while char_ready is high; the
// character port sets the sustained rate, and a short final group is padded to four characters too.
// Reset clears pending bytes, queue pointers and the character index.
// A stalled char port fills the queue, then byte_ready drops.
`default_nettype none
`include "assert_macros.svh"

module base64_stream_encoder
    import b64e_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    output logic            byte_ready,
    input  wire byte_item_t byte_item,
    output logic            char_valid,
    input  wire logic       char_ready,
    output char_item_t      char_item
);

    queue_status_t q_status;
    logic          push;
    logic          pop;
    group_t        push_group;
    group_t        head;

    b64e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .q_status   (q_status),
        .push       (push),
        .push_group (push_group)
    );

    b64e_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .pop        (pop),
        .head       (head),
        .q_status   (q_status)
    );

    b64e_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_status   (q_status),
        .pop        (pop),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item)
    );

    `ASSERT_ALWAYS(a_queue_status_sane, clk, rst_n, !(q_status.full && q_status.empty))
    `ASSERT_IMPLIES(a_done_is_last, clk, rst_n, char_item.message_done, char_item.last_in_run)
    `ASSERT_NEXT(a_eom_pushes_group, clk, rst_n, push && byte_item.end_of_message, char_valid)
    `ASSERT_IMPLIES(a_pop_only_when_valid, clk, rst_n, pop, char_valid && char_ready)

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Testbench for the Base64 stream encoder: directed and random messages checked per character.
`timescale 1ns / 1ps

module testbench;
    import b64e_pkg::*;

    localparam logic [8*64-1:0] SYMBOLS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_ready;
    byte_item_t byte_item = '0;
    logic       char_valid;
    logic       char_ready = 1'b0;
    char_item_t char_item;

    char_item_t expected_chars[$];
    logic [7:0] pend_first;
    logic [7:0] pend_second;
    int         pend_count;
    int         errors;
    int         burst_left;
    bit         no_gaps;
    int         hold_cycles;
    int         bytes_sent;

    base64_stream_encoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        #2ms;
        $display("testbench failed");
        $finish;
    end

    function automatic logic [7:0] symbol_of(input logic [5:0] idx);
        return SYMBOLS[8*(63 - idx) +: 8];
    endfunction

    task automatic report(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic push_char(input logic [7:0] ch, input logic last, input logic done);
        char_item_t c;
        c.out_char     = ch;
        c.last_in_run  = last;
        c.message_done = done;
        expected_chars.push_back(c);
    endtask

    task automatic predict_encoding(input byte_item_t it);
        logic [23:0] grp;
        logic [7:0]  c2;
        logic [7:0]  c3;
        if (pend_count < 2 && !it.end_of_message)
        begin
            if (pend_count == 0)
                pend_first = it.data_byte;
            else
                pend_second = it.data_byte;
            pend_count++;
            return;
        end
        if (pend_count == 2)
        begin
            grp = {pend_first, pend_second, it.data_byte};
            c2  = symbol_of(grp[11:6]);
            c3  = symbol_of(grp[5:0]);
        end
        else if (pend_count == 1)
        begin
            grp = {pend_first, it.data_byte, 8'h00};
            c2  = symbol_of(grp[11:6]);
            c3  = PAD_CHAR;
        end
        else
        begin
            grp = {it.data_byte, 16'h0000};
            c2  = PAD_CHAR;
            c3  = PAD_CHAR;
        end
        push_char(symbol_of(grp[23:18]), 1'b0, 1'b0);
        push_char(symbol_of(grp[17:12]), 1'b0, 1'b0);
        push_char(c2, 1'b0, 1'b0);
        push_char(c3, 1'b1, it.end_of_message);
        pend_first  = '0;
        pend_second = '0;
        pend_count  = 0;
    endtask

    task automatic send_byte(input logic [7:0] data, input logic eom);
        byte_item_t it;
        it.data_byte      = data;
        it.end_of_message = eom;
        byte_valid <= 1'b1;
        byte_item  <= it;
        do
            @(posedge clk);
        while (!byte_ready);
        predict_encoding(it);
        bytes_sent++;
        if (!no_gaps)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                byte_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                         : $urandom_range(1, 8);
            end
        end
    endtask

    task automatic wait_drain();
        while (expected_chars.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Receiver: check each item, then pick ready for the next cycle.
    initial
    begin
        char_item_t exp_c;
        int mode;
        int mode_left;
        int phase;
        mode      = 0;
        mode_left = 0;
        phase     = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && char_valid && char_ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    report($sformatf("unexpected char 0x%02h", char_item.out_char));
                end
                else
                begin
                    exp_c = expected_chars.pop_front();
                    if (char_item.out_char !== exp_c.out_char)
                        report($sformatf("out_char 0x%02h, expected 0x%02h",
                                         char_item.out_char, exp_c.out_char));
                    if (char_item.last_in_run !== exp_c.last_in_run)
                        report($sformatf("last_in_run %b, expected %b",
                                         char_item.last_in_run, exp_c.last_in_run));
                    if (char_item.message_done !== exp_c.message_done)
                        report($sformatf("message_done %b, expected %b",
                                         char_item.message_done, exp_c.message_done));
                end
            end
            if (mode_left <= 0)
            begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            phase++;
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                char_ready <= 1'b0;
            end
            else if (mode == 0)
                char_ready <= 1'b1;
            else if (mode == 1)
                char_ready <= 1'($urandom_range(0, 1));
            else
                char_ready <= (phase % 3 == 0);
        end
    end

    task automatic test_short_groups();
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_full_groups();
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hC3, 1'b1);
        send_byte(8'h3C, 1'b0);
        send_byte(8'h96, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
        send_byte(8'h78, 1'b1);
    endtask

    task automatic test_random_messages(input int count);
        int len;
        int target;
        target = bytes_sent + count;
        while (bytes_sent < target)
        begin
            len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 9) : $urandom_range(1, 3);
            if (len > target - bytes_sent)
                len = target - bytes_sent;
            for (int i = 0; i < len; i++)
                send_byte(8'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    task automatic test_backpressure();
        no_gaps     = 1'b1;
        hold_cycles = 300;
        for (int i = 0; i < 24; i++)
            send_byte(8'($urandom_range(0, 255)), i == 23);
        byte_valid <= 1'b0;
        no_gaps = 1'b0;
        wait_drain();
    endtask

    initial
    begin
        errors      = 0;
        pend_first  = '0;
        pend_second = '0;
        pend_count  = 0;
        burst_left  = 4;
        no_gaps     = 1'b0;
        hold_cycles = 0;
        bytes_sent  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_groups();
        test_full_groups();
        test_backpressure();
        test_random_messages(84);
        byte_valid <= 1'b0;
        wait_drain();

        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/b64e_pkg.sv
src/b64e_front.sv
src/b64e_queue.sv
src/b64e_back.sv
src/base64_stream_encoder.sv
verif/testbench.sv
